// File: hw/rtl/spq_pkg.sv
// spq_pkg: shared constants, codes and control types for the sorted priority queue
// no dependencies; read first by every file of the block that imports it
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int PRIO_W   = 16;
  localparam int VALUE_W  = 32;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_DUMP   = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_BADOP = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SEND = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    do_insert;
    logic    do_remove;
    logic    dump_first;
    logic    dump_next;
    logic    load_code;
    status_t code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic more;
  } stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/spq_if.sv
// spq_in_if / spq_out_if: valid-ready channels carrying one input and one result word
// depend on nothing; field widths follow the block's item layout
`timescale 1ns / 1ps
`default_nettype none

interface spq_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  func;
  logic signed [15:0] prio_in;
  logic signed [31:0] value_in;

  modport source (output valid, output func, output prio_in, output value_in, input ready);
  modport sink   (input valid, input func, input prio_in, input value_in, output ready);
endinterface

interface spq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_out;
  logic signed [15:0] prio_out;
  logic        [1:0]  status;
  logic               last;

  modport source (output valid, output value_out, output prio_out, output status,
                  output last, input ready);
  modport sink   (input valid, input value_out, input prio_out, input status,
                  input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sorted_priority_queue_unit.sv
// a result word is offered in the cycle after its input word is taken
// insert, remove and bad operations: the next input word waits until the result word is taken
// n-entry dump: n words, one per cycle unless stalled, paced by the single result register
// the chain is rotated once per dumped word and ends back in its original order
// reset (synchronous, active high) empties the queue; the cells themselves are not cleared
// sorted_priority_queue_unit: top level, joins controller, datapath and the two channels
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_unit (
  input wire        clk,
  input wire        rst,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  // command and status between the two halves
  cmd_t    cmd;
  stat_t   stat;
  status_t res_status;

  // controller: accepts a word only when no result is pending
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  // datapath: the sorted chain of cells, shifted in parallel on insert, remove and dump
  spq_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .ins_prio   (in_ch.prio_in),
    .ins_value  (in_ch.value_in),
    .stat       (stat),
    .res_value  (out_ch.value_out),
    .res_prio   (out_ch.prio_out),
    .res_status (res_status),
    .res_last   (out_ch.last)
  );

  // status code onto the plain channel field
  assign out_ch.status = res_status;

endmodule

`default_nettype wire

// File: hw/rtl/spq_datapath.sv
// spq_datapath: sorted cell chain, entry count, dump counter and result register
// depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath (
  input  wire                            clk,
  input  wire                            rst,
  input  spq_pkg::cmd_t                  cmd,
  input  wire signed [spq_pkg::PRIO_W-1:0]  ins_prio,
  input  wire signed [spq_pkg::VALUE_W-1:0] ins_value,
  output spq_pkg::stat_t                 stat,
  output logic signed [spq_pkg::VALUE_W-1:0] res_value,
  output logic signed [spq_pkg::PRIO_W-1:0]  res_prio,
  output spq_pkg::status_t               res_status,
  output logic                           res_last
);
  import spq_pkg::*;

  logic signed [PRIO_W-1:0]  cell_prio       [CAPACITY];
  logic signed [VALUE_W-1:0] cell_value      [CAPACITY];
  logic signed [PRIO_W-1:0]  cell_prio_next  [CAPACITY];
  logic signed [VALUE_W-1:0] cell_value_next [CAPACITY];
  logic [CAPACITY-1:0]       after_new;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          left;
  logic                      rotate;

  assign rotate = cmd.dump_first | cmd.dump_next;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(CAPACITY));
  assign stat.more  = (left != '0);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    // cell holds an entry that the new one goes in front of
    assign after_new[i] = (CNT_W'(i) < count) && (cell_prio[i] < ins_prio);

    always_comb begin
      cell_prio_next[i]  = cell_prio[i];
      cell_value_next[i] = cell_value[i];
      if (cmd.do_insert) begin
        if (i > 0 && after_new[(i > 0) ? i - 1 : 0]) begin
          cell_prio_next[i]  = cell_prio[(i > 0) ? i - 1 : 0];
          cell_value_next[i] = cell_value[(i > 0) ? i - 1 : 0];
        end else if (after_new[i] || CNT_W'(i) == count) begin
          cell_prio_next[i]  = ins_prio;
          cell_value_next[i] = ins_value;
        end
      end else if (cmd.do_remove) begin
        if (i < CAPACITY - 1) begin
          cell_prio_next[i]  = cell_prio[(i < CAPACITY - 1) ? i + 1 : i];
          cell_value_next[i] = cell_value[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end else if (rotate) begin
        // head wraps round to the tail of the occupied cells
        if (CNT_W'(i + 1) == count) begin
          cell_prio_next[i]  = cell_prio[0];
          cell_value_next[i] = cell_value[0];
        end else if (i < CAPACITY - 1 && CNT_W'(i + 1) < count) begin
          cell_prio_next[i]  = cell_prio[(i < CAPACITY - 1) ? i + 1 : i];
          cell_value_next[i] = cell_value[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end

    always_ff @(posedge clk) begin
      cell_prio[i]  <= cell_prio_next[i];
      cell_value[i] <= cell_value_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      left  <= '0;
    end else begin
      if (cmd.do_insert) begin
        count <= count + CNT_W'(1);
      end else if (cmd.do_remove) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.dump_first) begin
        left <= count - CNT_W'(1);
      end else if (cmd.dump_next) begin
        left <= left - CNT_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.do_remove || rotate) begin
      res_value  <= cell_value[0];
      res_prio   <= cell_prio[0];
      res_status <= STATUS_OK;
      if (cmd.dump_first) begin
        res_last <= (count == CNT_W'(1));
      end else if (cmd.dump_next) begin
        res_last <= (left == CNT_W'(1));
      end else begin
        res_last <= 1'b1;
      end
    end else if (cmd.load_code) begin
      res_value  <= '0;
      res_prio   <= '0;
      res_status <= cmd.code;
      res_last   <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/spq_ctrl.sv
// spq_ctrl: two-state controller that decodes the operation and paces results
// depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  input  wire [spq_pkg::FUNC_W-1:0]    in_func,
  input  wire                          out_ready,
  input  spq_pkg::stat_t               stat,
  output logic                         in_ready,
  output logic                         out_valid,
  output spq_pkg::cmd_t                cmd
);
  import spq_pkg::*;

  state_t state;
  state_t state_next;
  logic   in_take;
  logic   out_take;

  assign in_take  = in_valid && (state == ST_IDLE);
  assign out_take = out_ready && (state == ST_SEND);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_ready && !stat.more) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_SEND);
    cmd       = '0;
    cmd.code  = STATUS_OK;
    if (in_take) begin
      case (func_t'(in_func))
        FUNC_INSERT: begin
          cmd.load_code = 1'b1;
          if (stat.full) begin
            cmd.code = STATUS_FULL;
          end else begin
            cmd.do_insert = 1'b1;
          end
        end
        FUNC_REMOVE: begin
          if (stat.empty) begin
            cmd.load_code = 1'b1;
            cmd.code      = STATUS_EMPTY;
          end else begin
            cmd.do_remove = 1'b1;
          end
        end
        FUNC_DUMP: begin
          if (stat.empty) begin
            cmd.load_code = 1'b1;
            cmd.code      = STATUS_EMPTY;
          end else begin
            cmd.dump_first = 1'b1;
          end
        end
        default: begin
          cmd.load_code = 1'b1;
          cmd.code      = STATUS_BADOP;
        end
      endcase
    end else if (out_take && stat.more) begin
      cmd.dump_next = 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/spq_checker.sv
// spq_checker: port-level checks on the sorted priority queue, bound to the top level
// depends on spq_pkg and sorted_priority_queue_unit
`timescale 1ns / 1ps
`default_nettype none

module spq_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] value_out,
  input wire [15:0] prio_out,
  input wire [1:0]  status,
  input wire        last
);
  import spq_pkg::*;

  // a new word is never taken while a result is still on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while result pending");

  // reset leaves no result on offer
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  // error results are single words with an empty payload
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_OK) |-> (last && value_out == '0 && prio_out == '0))
    else $error("error result malformed");

  // every taken input word gets its result in the next cycle
  a_prompt: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("no result after accepted input");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(value_out) && $stable(prio_out)
                                   && $stable(status) && $stable(last)))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .value_out (out_ch.value_out),
  .prio_out  (out_ch.prio_out),
  .status    (out_ch.status),
  .last      (out_ch.last)
);

`default_nettype wire

// File: sim/sorted_priority_queue_unit_tb.sv
// sorted_priority_queue_unit_tb: self-checking bench for the sorted priority queue top level
// depends on spq_pkg, spq_in_if / spq_out_if and sorted_priority_queue_unit
`timescale 1ns / 1ps

module sorted_priority_queue_unit_tb;
  import spq_pkg::*;

  // func value with no operation behind it
  localparam logic [FUNC_W-1:0] FUNC_BAD = 2'd3;

  // run guard, several times the slowest legal run
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 180;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTED = 30;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BLEND
  } mix_t;

  // one input word, optionally with its single result fixed by hand
  typedef struct {
    logic [FUNC_W-1:0]         func;
    logic signed [PRIO_W-1:0]  prio;
    logic signed [VALUE_W-1:0] value;
    bit                        pinned;
    status_t                   pin_status;
  } op_word_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
    status_t                   status;
    logic                      last;
  } result_word_t;

  logic clk;
  logic rst;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue_unit uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the queue, head at index 0
  logic signed [PRIO_W-1:0]  shadow_prio [CAPACITY];
  logic signed [VALUE_W-1:0] shadow_value [CAPACITY];
  int                        shadow_count;

  result_word_t awaited_results [$];
  op_word_t     directed_ops [$];
  op_word_t     offered_op;

  int  errors;
  int  cycle_count;
  int  op_tally [4];
  int  result_tally;
  int  full_hits;
  int  empty_hits;
  int  peak_fill;
  bit  rx_hold_req;
  bit  tx_steady;
  bit  rx_steady;

  result_word_t head_exp;
  int           depth_before;

  // clock, 12 ns period
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // every block input known from time zero
  initial begin
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_INSERT;
    in_ch.prio_in   = '0;
    in_ch.value_in  = '0;
    out_ch.ready    = 1'b0;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still awaited", cycle_count,
               awaited_results.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic flag_error(input string what);
    errors++;
    if (errors <= MAX_PRINTED) $display("mismatch @%0t: %s", $realtime, what);
  endtask

  // works out the result words one input word causes and updates the shadow queue
  task automatic predict_queue_response(input logic [FUNC_W-1:0] func,
                                        input logic signed [PRIO_W-1:0] prio,
                                        input logic signed [VALUE_W-1:0] value);
    result_word_t r;
    int           pos;
    r.value  = '0;
    r.prio   = '0;
    r.status = STATUS_OK;
    r.last   = 1'b1;
    case (func)
      FUNC_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          // store full: entry dropped, queue untouched
          r.status = STATUS_FULL;
          full_hits++;
        end else begin
          // first stored entry of strictly lower priority, so equal ones keep arrival order
          pos = shadow_count;
          for (int i = shadow_count - 1; i >= 0; i--) begin
            if (shadow_prio[i] < prio) pos = i;
          end
          for (int i = shadow_count; i > pos; i--) begin
            shadow_prio[i]  = shadow_prio[i-1];
            shadow_value[i] = shadow_value[i-1];
          end
          shadow_prio[pos]  = prio;
          shadow_value[pos] = value;
          shadow_count++;
          if (shadow_count > peak_fill) peak_fill = shadow_count;
        end
        awaited_results.push_back(r);
      end
      FUNC_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = STATUS_EMPTY;
          empty_hits++;
        end else begin
          r.value = shadow_value[0];
          r.prio  = shadow_prio[0];
          for (int i = 1; i < shadow_count; i++) begin
            shadow_prio[i-1]  = shadow_prio[i];
            shadow_value[i-1] = shadow_value[i];
          end
          shadow_count--;
        end
        awaited_results.push_back(r);
      end
      FUNC_DUMP: begin
        if (shadow_count == 0) begin
          r.status = STATUS_EMPTY;
          empty_hits++;
          awaited_results.push_back(r);
        end else begin
          // whole queue from the head, last mark on the tail entry
          for (int i = 0; i < shadow_count; i++) begin
            r.value = shadow_value[i];
            r.prio  = shadow_prio[i];
            r.last  = (i == shadow_count - 1);
            awaited_results.push_back(r);
          end
        end
      end
      default: begin
        r.status = STATUS_BADOP;
        awaited_results.push_back(r);
      end
    endcase
  endtask

  // monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        result_tally++;
        if (awaited_results.size() == 0) begin
          flag_error($sformatf("unexpected result word value %h prio %h status %0d last %b",
                               out_ch.value_out, out_ch.prio_out, out_ch.status,
                               out_ch.last));
        end else begin
          head_exp = awaited_results.pop_front();
          if (out_ch.value_out !== head_exp.value)
            flag_error($sformatf("value_out %h, expected %h", out_ch.value_out,
                                 head_exp.value));
          if (out_ch.prio_out !== head_exp.prio)
            flag_error($sformatf("prio_out %h, expected %h", out_ch.prio_out,
                                 head_exp.prio));
          if (out_ch.status !== head_exp.status)
            flag_error($sformatf("status %0d, expected %0d", out_ch.status,
                                 head_exp.status));
          if (out_ch.last !== head_exp.last)
            flag_error($sformatf("last %b, expected %b", out_ch.last, head_exp.last));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        op_tally[in_ch.func]++;
        depth_before = awaited_results.size();
        predict_queue_response(in_ch.func, in_ch.prio_in, in_ch.value_in);
        // hand-written rows replace the predicted word, the shadow queue still moves on
        if (offered_op.pinned) begin
          while (awaited_results.size() > depth_before) void'(awaited_results.pop_back());
          head_exp.value  = '0;
          head_exp.prio   = '0;
          head_exp.status = offered_op.pin_status;
          head_exp.last   = 1'b1;
          awaited_results.push_back(head_exp);
        end
      end
    end
  end

  // receiver: random hold-off per word, plus one long stall on request
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        // long stall so the single result register backs up into the input side
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  // sender side: offer one word, wait for the handshake, return on the next falling edge
  task automatic offer_word(input op_word_t w);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    offered_op     = w;
    in_ch.func     = w.func;
    in_ch.prio_in  = w.prio;
    in_ch.value_in = w.value;
    in_ch.valid    = 1'b1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
  endtask

  task automatic add_op(input logic [FUNC_W-1:0] func, input logic signed [PRIO_W-1:0] prio,
                        input logic signed [VALUE_W-1:0] value, input bit pinned,
                        input status_t pin_status);
    op_word_t w;
    w.func       = func;
    w.prio       = prio;
    w.value      = value;
    w.pinned     = pinned;
    w.pin_status = pin_status;
    directed_ops.push_back(w);
  endtask

  function automatic logic [FUNC_W-1:0] pick_func(input mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 80) return FUNC_INSERT;
        if (r < 90) return FUNC_REMOVE;
        if (r < 97) return FUNC_DUMP;
      end
      MIX_DRAIN: begin
        if (r < 15) return FUNC_INSERT;
        if (r < 90) return FUNC_REMOVE;
        if (r < 97) return FUNC_DUMP;
      end
      default: begin
        if (r < 45) return FUNC_INSERT;
        if (r < 85) return FUNC_REMOVE;
        if (r < 97) return FUNC_DUMP;
      end
    endcase
    return FUNC_BAD;
  endfunction

  // priorities cluster on a few values so ties are common, with extremes and full-range noise
  function automatic logic signed [PRIO_W-1:0] pick_prio();
    int pick;
    int near;
    pick = $urandom_range(0, 3);
    near = $urandom_range(0, 4);
    if (pick < 2) return PRIO_W'(near - 2);
    if (pick == 2) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return PRIO_W'($urandom);
  endfunction

  // main sequence
  initial begin
    op_word_t w;
    mix_t     mix;
    int       mix_left;
    errors       = 0;
    cycle_count  = 0;
    result_tally = 0;
    full_hits    = 0;
    empty_hits   = 0;
    peak_fill    = 0;
    shadow_count = 0;
    rx_hold_req  = 1'b0;
    tx_steady    = 1'b0;
    rx_steady    = 1'b0;
    offered_op   = '{default: '0, pin_status: STATUS_OK};
    foreach (op_tally[i]) op_tally[i] = 0;

    // directed rows: empty queue, bad operation, extremes, ties, filling to the brim
    add_op(FUNC_REMOVE, 16'sh0000, 32'sh00000000, 1'b1, STATUS_EMPTY);
    add_op(FUNC_DUMP,   16'sh0000, 32'sh00000000, 1'b1, STATUS_EMPTY);
    add_op(FUNC_BAD,    16'sh7fff, 32'shffffffff, 1'b1, STATUS_BADOP);
    add_op(FUNC_INSERT, 16'sh7fff, 32'sh7fffffff, 1'b1, STATUS_OK);
    add_op(FUNC_INSERT, 16'sh8000, 32'sh80000000, 1'b1, STATUS_OK);
    add_op(FUNC_INSERT, 16'sh0000, 32'sh00000000, 1'b1, STATUS_OK);
    // equal priority lands behind the earlier one
    add_op(FUNC_INSERT, 16'sh0000, 32'sh00000001, 1'b1, STATUS_OK);
    add_op(FUNC_INSERT, 16'shffff, 32'shffffffff, 1'b1, STATUS_OK);
    add_op(FUNC_INSERT, 16'sh7fff, 32'sh00000005, 1'b1, STATUS_OK);
    add_op(FUNC_DUMP,   16'sh0000, 32'sh00000000, 1'b0, STATUS_OK);
    add_op(FUNC_REMOVE, 16'sh0000, 32'sh00000000, 1'b0, STATUS_OK);
    for (int i = 0; i < CAPACITY - 5; i++)
      add_op(FUNC_INSERT, PRIO_W'((i % 4) * 1000 - 1500), VALUE_W'(32'h1000 + i), 1'b1,
             STATUS_OK);
    // one more than the store holds
    add_op(FUNC_INSERT, 16'sh7fff, 32'sh12345678, 1'b1, STATUS_FULL);
    add_op(FUNC_DUMP,   16'sh0000, 32'sh00000000, 1'b0, STATUS_OK);
    add_op(FUNC_BAD,    16'sh0000, 32'sh00000000, 1'b1, STATUS_BADOP);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_ops[i]) offer_word(directed_ops[i]);

    // random part: fill, drain and blended phases so the queue swings between empty and full
    mix      = MIX_DRAIN;
    mix_left = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (mix_left == 0) begin
        mix      = mix_t'($urandom_range(0, 2));
        mix_left = $urandom_range(12, 30);
      end
      mix_left--;
      if (n == 40) rx_hold_req = 1'b1;
      w.func       = pick_func(mix);
      w.prio       = pick_prio();
      w.value      = VALUE_W'($urandom);
      w.pinned     = 1'b0;
      w.pin_status = STATUS_OK;
      offer_word(w);
    end
    in_ch.valid = 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d inserts, %0d removes, %0d dumps, %0d bad ops; %0d result words",
             op_tally[FUNC_INSERT], op_tally[FUNC_REMOVE], op_tally[FUNC_DUMP],
             op_tally[FUNC_BAD], result_tally);
    $display("queue peaked at %0d of %0d, %0d full drops, %0d empty hits, %0d mismatches",
             peak_fill, CAPACITY, full_hits, empty_hits, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
